@@ hdl/lgs_pkg.sv @@
// Package for the life grid generation step block: payload types, command codes
// and default grid size. It has no dependencies; the top level, the checker and the testbench import it.
`default_nettype none

package lgs_pkg;

  // Default grid size.
  localparam int unsigned ROWS_DEF = 16;
  localparam int unsigned COLS_DEF = 16;

  // Widths of the fixed command fields.
  localparam int unsigned ROW_W  = 4;
  localparam int unsigned COL_W  = 4;
  localparam int unsigned MODE_W = 2;

  // Command codes. MODE_NOP completes without touching the grid.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // One command transfer.
  typedef struct packed {
    mode_e            mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             alive_in;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic alive_out;
    logic done_res;
  } out_t;

endpackage

`default_nettype wire

@@ hdl/lgs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lgs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/lgs_row_unit.sv @@
// Next-generation logic for one grid row, given the rows above and below.
// Used once per cycle by the sweep in the top level; no dependencies.
`default_nettype none

module lgs_row_unit #(
  parameter int unsigned COLS = 16
) (
  input  wire logic [COLS-1:0] above_i,
  input  wire logic [COLS-1:0] center_i,
  input  wire logic [COLS-1:0] below_i,
  output logic      [COLS-1:0] next_o
);

  localparam int unsigned NBR_W       = 4;
  localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_CNT = NBR_W'(2);

  // Rows padded with a dead cell on each side, so edges need no special case.
  logic [COLS+1:0] above_pad;
  logic [COLS+1:0] center_pad;
  logic [COLS+1:0] below_pad;

  assign above_pad  = {1'b0, above_i, 1'b0};
  assign center_pad = {1'b0, center_i, 1'b0};
  assign below_pad  = {1'b0, below_i, 1'b0};

  // Count the eight neighbors of each column and apply the B3/S23 rule.
  always_comb begin
    logic [NBR_W-1:0] nbr;
    for (int c = 0; c < COLS; c++) begin
      nbr = NBR_W'(above_pad[c]) + NBR_W'(above_pad[c+1]) + NBR_W'(above_pad[c+2])
          + NBR_W'(center_pad[c]) + NBR_W'(center_pad[c+2])
          + NBR_W'(below_pad[c]) + NBR_W'(below_pad[c+1]) + NBR_W'(below_pad[c+2]);
      next_o[c] = (nbr == BIRTH_CNT) || (center_i[c] && (nbr == SURVIVE_CNT));
    end
  end

endmodule

`default_nettype wire

@@ hdl/life_grid_generation_step.sv @@
// Sequence: a cell write or cell read goes through ST_CELL, a no-op through ST_RESP,
// a generation step through ST_GEN, ST_GEN_TAIL and ST_RESP; all end in out_q.
// Throughput: one command at a time; the step sweeps one grid row per cycle
// through the shared row unit and the single read port of the grid RAM.
// Reset (asynchronous, active low) returns to idle and marks every row dead at
// once through per-row valid flags; no clearing pass is needed.
`default_nettype none

module life_grid_generation_step #(
  parameter int unsigned ROWS = lgs_pkg::ROWS_DEF,
  parameter int unsigned COLS = lgs_pkg::COLS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire lgs_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output lgs_pkg::out_t     out_data_o
);

  import lgs_pkg::*;

  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_GEN,
    ST_GEN_TAIL,
    ST_RESP
  } state_e;

  state_e          state_q, state_d;
  logic [RW-1:0]   cnt_q, cnt_d;
  in_t             cmd_q, cmd_d;
  logic            inside_q, inside_d;
  logic [COLS-1:0] prev_q, prev_d;
  logic [COLS-1:0] cur_q, cur_d;
  logic [ROWS-1:0] vld_q, vld_d;
  logic            rd_vld_q, rd_vld_d;
  logic            out_vld_q, out_vld_d;
  out_t            out_q, out_d;

  logic            in_xfer;
  logic            out_free;
  logic            rd_en;
  logic [RW-1:0]   rd_addr;
  logic            wr_en;
  logic [RW-1:0]   wr_addr;
  logic [COLS-1:0] wr_data;
  logic [COLS-1:0] ram_rd_data;
  logic [COLS-1:0] rd_row;
  logic [COLS-1:0] below_row;
  logic [COLS-1:0] next_row;
  logic [COLS-1:0] bit_mask;

  logic [RW+ROW_W-1:0] row_ext;
  logic [CW+COL_W-1:0] col_ext;
  logic [CW+COL_W-1:0] cmd_col_ext;
  logic                in_inside;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Address range check of the incoming command.
  assign row_ext     = (RW + ROW_W)'(in_data_i.row);
  assign col_ext     = (CW + COL_W)'(in_data_i.col);
  assign cmd_col_ext = (CW + COL_W)'(cmd_q.col);
  assign in_inside   = (row_ext < (RW + ROW_W)'(ROWS)) && (col_ext < (CW + COL_W)'(COLS));

  // A row never written since reset reads as all dead.
  assign rd_row    = rd_vld_q ? ram_rd_data : '0;
  assign below_row = (state_q == ST_GEN) ? rd_row : '0;
  assign bit_mask  = COLS'(1) << cmd_col_ext[CW-1:0];

  lgs_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd_data)
  );

  lgs_row_unit #(
    .COLS (COLS)
  ) u_row_unit (
    .above_i  (prev_q),
    .center_i (cur_q),
    .below_i  (below_row),
    .next_o   (next_row)
  );

  // Sequencer: a cell write does a read-modify-write, a cell read only reads; a step
  // sweeps rows in a three-row window, writing each new row behind the read pointer.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    inside_d  = inside_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    vld_d     = vld_q;
    rd_vld_d  = rd_vld_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = cnt_q - RW'(1);
    wr_data   = next_row;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_d    = in_data_i;
          inside_d = in_inside;
          cnt_d    = '0;
          prev_d   = '0;
          cur_d    = '0;
          unique case (in_data_i.mode)
            MODE_WRITE, MODE_READ: begin
              rd_en   = in_inside;
              rd_addr = row_ext[RW-1:0];
              state_d = ST_CELL;
            end
            MODE_STEP: begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_GEN;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_CELL: begin
        if (out_free) begin
          wr_en     = (cmd_q.mode == MODE_WRITE) && inside_q;
          wr_addr   = (RW + ROW_W)'(cmd_q.row) >> 0 == '0 ? '0 : RW'(cmd_q.row);
          wr_data   = cmd_q.alive_in ? (rd_row | bit_mask) : (rd_row & ~bit_mask);
          out_vld_d = 1'b1;
          out_d.alive_out = (cmd_q.mode == MODE_READ) && inside_q
                            && rd_row[cmd_col_ext[CW-1:0]];
          out_d.done_res  = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      ST_GEN: begin
        // Row cnt_q has arrived; new row cnt_q - 1 is ready.
        wr_en  = (cnt_q != '0);
        prev_d = cur_q;
        cur_d  = rd_row;
        if (cnt_q == LAST_ROW) begin
          state_d = ST_GEN_TAIL;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cnt_q + RW'(1);
          cnt_d   = cnt_q + RW'(1);
        end
      end

      ST_GEN_TAIL: begin
        // Last row sees a dead row below it.
        wr_en   = 1'b1;
        wr_addr = LAST_ROW;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_vld_d       = 1'b1;
          out_d.alive_out = 1'b0;
          out_d.done_res  = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (rd_en) begin
      rd_vld_d = vld_q[rd_addr];
    end
    if (wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  // State, row flags and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      vld_q     <= vld_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    inside_q <= inside_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

@@ hdl/lgs_checker.sv @@
// Port-level checks for the life grid generation step block, bound to its top level.
// Depends on lgs_pkg for the payload types.
`default_nettype none

module lgs_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire lgs_pkg::out_t out_data_o
);

  import lgs_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] open_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Commands accepted whose results have not yet been transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  // Every result reports a completed command.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.done_res)
    else $error("result without done flag");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed before transfer");

  // The block is busy in the cycle after it takes a command.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("command taken in back-to-back cycles");

  // No result appears without a command to answer, and at most two are open.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o |-> open_q != 2'd0) and (open_q != 2'd3))
    else $error("result count does not match commands");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for life_grid_generation_step: directed commands, then random ones.
// It keeps its own copy of the grid to predict each result. It depends only on lgs_pkg and the block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;

  localparam int ROWS = ROWS_DEF;
  localparam int COLS = COLS_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int IDLE_MAX = 12;
  localparam int RANDOM_ITEMS = 800;
  localparam int SEGMENT_ITEMS = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = ROWS + 10;

  // One directed command, with its result typed in where it is obvious.
  typedef struct {
    in_t  cmd;
    bit   typed;
    out_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Predicted grid, the snapshot used during a generation, and pending results.
  logic [COLS-1:0] life_q [ROWS];
  logic [COLS-1:0] snap_q [ROWS];
  out_t            result_q [$];
  vector_t         directed_q [$];

  int  errors = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;
  int  density = 4;

  life_grid_generation_step uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Cells outside the grid count as dead.
  function automatic int live_at(input int r, input int c);
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 0;
    return int'(snap_q[r][c]);
  endfunction

  // One B3/S23 generation computed from a snapshot of the whole grid.
  function automatic void next_generation();
    int n;
    snap_q = life_q;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += live_at(r + dr, c + dc);
          end
        end
        life_q[r][c] = (n == 3) || (snap_q[r][c] && n == 2);
      end
    end
  endfunction

  function automatic out_t predict_command(input in_t cmd);
    out_t res;
    bit   on_grid;
    res.alive_out = 1'b0;
    res.done_res  = 1'b1;
    on_grid = int'(cmd.row) < ROWS && int'(cmd.col) < COLS;
    case (cmd.mode)
      MODE_WRITE: begin
        if (on_grid) life_q[cmd.row][cmd.col] = cmd.alive_in;
      end
      MODE_STEP: begin
        next_generation();
      end
      MODE_READ: begin
        if (on_grid) res.alive_out = life_q[cmd.row][cmd.col];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic add_vector(input mode_e m, input int r, input int c, input bit a,
                            input bit typed, input bit want_alive);
    vector_t v;
    v.cmd.mode          = m;
    v.cmd.row           = ROW_W'(r);
    v.cmd.col           = COL_W'(c);
    v.cmd.alive_in      = a;
    v.typed             = typed;
    v.want.alive_out    = want_alive;
    v.want.done_res     = 1'b1;
    directed_q.push_back(v);
  endtask

  // Offer one command after a random gap; record its result once the transfer happens.
  task automatic send_command(input in_t cmd, input bit typed, input out_t want);
    int   gap;
    out_t predicted;
    gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = predict_command(cmd);
    result_q.push_back(typed ? want : predicted);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, each transfer checked against the oldest expectation.
  initial begin
    int   gap;
    out_t want;
    forever begin
      gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result %b with none expected", out_data));
      end else begin
        want = result_q.pop_front();
        if (out_data.alive_out !== want.alive_out)
          report_mismatch($sformatf("alive_out got %b want %b", out_data.alive_out,
                                    want.alive_out));
        if (out_data.done_res !== want.done_res)
          report_mismatch($sformatf("done_res got %b want %b", out_data.done_res,
                                    want.done_res));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random commands, drain.
  initial begin
    in_t  cmd;
    out_t none;
    int   pick;
    none = '0;
    foreach (life_q[r]) life_q[r] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Corners after reset, writes and reads at the extremes, the unused mode,
    // and small patterns touching the grid edges that must not wrap round.
    add_vector(MODE_READ,   0,  0, 1'b0, 1'b1, 1'b0);
    add_vector(MODE_READ,  15, 15, 1'b0, 1'b1, 1'b0);
    add_vector(MODE_WRITE,  0,  0, 1'b1, 1'b1, 1'b0);
    add_vector(MODE_READ,   0,  0, 1'b0, 1'b1, 1'b1);
    add_vector(MODE_WRITE, 15, 15, 1'b1, 1'b1, 1'b0);
    add_vector(MODE_READ,  15, 15, 1'b1, 1'b1, 1'b1);
    add_vector(MODE_NOP,   15, 15, 1'b1, 1'b1, 1'b0);
    add_vector(MODE_STEP,   0,  0, 1'b0, 1'b1, 1'b0);
    add_vector(MODE_READ,   0,  0, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_WRITE,  0, 14, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_WRITE,  0, 15, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_WRITE,  1, 15, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_WRITE, 15,  0, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_WRITE, 15,  1, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_WRITE, 14,  0, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_WRITE,  7,  7, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_WRITE,  7,  8, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_STEP,  15, 15, 1'b1, 1'b0, 1'b0);
    add_vector(MODE_READ,   1, 14, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_READ,  14,  1, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_STEP,   0,  0, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_READ,   0, 15, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_WRITE,  0, 15, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_READ,   0, 15, 1'b0, 1'b0, 1'b0);
    add_vector(MODE_READ,   7,  7, 1'b0, 1'b0, 1'b0);

    foreach (directed_q[i]) send_command(directed_q[i].cmd, directed_q[i].typed,
                                         directed_q[i].want);
    drain_results();

    // Random part: segments with their own cell density and idling behavior, so
    // the grid goes from sparse to crowded and generations have real work to do.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT_ITEMS == 0) begin
        density = $urandom_range(0, 8);
        calm    = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_ITEMS / 2) drain_results();
      pick         = $urandom_range(0, 99);
      cmd.mode     = (pick < 45) ? MODE_WRITE :
                     (pick < 75) ? MODE_READ  :
                     (pick < 90) ? MODE_STEP  : MODE_NOP;
      cmd.row      = ROW_W'($urandom_range(0, 15));
      cmd.col      = COL_W'($urandom_range(0, 15));
      cmd.alive_in = ($urandom_range(0, 7) < density);
      send_command(cmd, 1'b0, none);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
